FILE: rtl/rafa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle aspect fit and align: shared definitions
// Word sizes, register and mode codes, pipeline records and small helpers
// used by the top level and the pipelined ratio divider.
// ----------------------------------------------------------------------------
package rafa_pkg;

  localparam int COORD_BITS     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int RATIO_BITS     = COORD_BITS - 1;
  localparam int DIV_STEPS      = COORD_BITS - 1;
  localparam int DIV_LAT        = DIV_STEPS + 1;
  localparam int CMP_BITS       = (FRAC_BITS + 1 > COORD_BITS) ? FRAC_BITS + 1 : COORD_BITS;
  localparam int PROD_BITS      = COORD_BITS + RATIO_BITS;
  localparam int SCALED_BITS    = PROD_BITS - FRAC_BITS;
  localparam int ANC_BITS       = COORD_BITS + 1;
  localparam int SUM_BITS       = COORD_BITS + 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [RATIO_BITS-1:0] ratio_t;
  typedef logic signed [ANC_BITS-1:0]   anc_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  localparam coord_t WORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam coord_t WORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

  typedef enum logic [1:0] {
    MODE_STRETCH,
    MODE_FIT,
    MODE_FILL,
    MODE_KEEP
  } mode_t;

  typedef enum logic [1:0] {
    ANCHOR_IGNORE,
    ANCHOR_NEAR,
    ANCHOR_FAR,
    ANCHOR_CENTER
  } anchor_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ASPECT_MODE,
    CFG_TGT_HORZ,
    CFG_TGT_VERT,
    CFG_SUBJ_HORZ,
    CFG_SUBJ_VERT
  } cfg_index_t;

  typedef struct packed {
    mode_t   aspect_mode;
    anchor_t tgt_horz;
    anchor_t tgt_vert;
    anchor_t subj_horz;
    anchor_t subj_vert;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    rect_t subj;
    rect_t tgt;
    mag_t  w_mag;
    mag_t  h_mag;
    logic  zero;
    cfg_t  cfg;
  } side_t;

  typedef struct packed {
    logic   valid;
    logic   sat;
    ratio_t quot;
  } div_res_t;

  typedef struct packed {
    coord_t val;
    logic   sat;
  } sat_coord_t;

  function automatic mag_t mag_of(input coord_t v);
    return v[COORD_BITS-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rafa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle aspect fit and align: pipelined ratio divider
// Computes floor((num << FRAC_BITS) / den) with one restoring step per
// stage, and flags quotients that do not fit the positive word range.
// ----------------------------------------------------------------------------
module rafa_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire rafa_pkg::mag_t    num,
  input  wire rafa_pkg::mag_t    den,
  output rafa_pkg::div_res_t     res
);

  localparam int W     = rafa_pkg::COORD_BITS;
  localparam int STEPS = rafa_pkg::DIV_STEPS;
  localparam int DW    = rafa_pkg::COORD_BITS + rafa_pkg::FRAC_BITS;
  localparam int HW    = rafa_pkg::FRAC_BITS + 1;
  localparam int CW    = rafa_pkg::CMP_BITS;

  logic [DW-1:0] dvd_full;
  logic [HW-1:0] dvd_high;
  logic          init_sat;

  logic             st_valid [0:STEPS];
  logic             st_sat   [0:STEPS];
  logic [W-1:0]     st_rem   [0:STEPS];
  logic [W-1:0]     st_den   [0:STEPS];
  logic [STEPS-1:0] st_low   [0:STEPS];
  logic [STEPS-1:0] st_q     [0:STEPS];

  assign dvd_full = {num, {rafa_pkg::FRAC_BITS{1'b0}}};
  assign dvd_high = dvd_full[DW-1:W-1];
  assign init_sat = CW'(dvd_high) >= CW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_sat[0] <= init_sat;
    st_rem[0] <= W'(dvd_high);
    st_den[0] <= den;
    st_low[0] <= dvd_full[W-2:0];
    st_q[0]   <= '0;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {st_rem[k], st_low[k][STEPS-1]};
    assign diff  = trial - {1'b0, st_den[k]};
    assign ge    = trial >= {1'b0, st_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      st_sat[k+1] <= st_sat[k];
      st_den[k+1] <= st_den[k];
      st_rem[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
      st_low[k+1] <= {st_low[k][STEPS-2:0], 1'b0};
      st_q[k+1]   <= {st_q[k][STEPS-2:0], ge};
    end
  end

  assign res = '{valid: st_valid[STEPS], sat: st_sat[STEPS], quot: st_q[STEPS]};

`ifndef ASSERT_OFF
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##(rafa_pkg::DIV_LAT) res.valid)
    else $error("Divider result did not appear after its fixed latency.");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.sat) |-> (st_rem[STEPS] < st_den[STEPS]))
    else $error("Divider remainder is not below the divisor.");

  a_div_zero_den: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (den == '0)) |-> ##(rafa_pkg::DIV_LAT) res.sat)
    else $error("Divider did not flag a zero divisor.");
`endif

endmodule
`default_nettype wire

FILE: rtl/rect_aspect_fit_align.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rectangle aspect fit and align
// Resizes a subject rectangle to a target (stretch, fit, fill or keep) and
// aligns the two by chosen anchors, in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high and busy is low;
// busy is only high during reset. The result appears on the output ports,
// marked by done for exactly one cycle, and one request may follow another
// on every cycle. The pipeline runs through the width and height ratio
// dividers, which resolve one quotient bit per stage over 31 stages,
// followed by ratio selection, a multiply, saturation, anchor and offset
// stages. The receiver cannot stall the block. The configuration registers
// are written through the cfg port, which is always ready, and should only
// be changed while no request is in flight.
module rect_aspect_fit_align (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire rafa_pkg::coord_t                     subj_x,
  input  wire rafa_pkg::coord_t                     subj_y,
  input  wire rafa_pkg::coord_t                     subj_w,
  input  wire rafa_pkg::coord_t                     subj_h,
  input  wire rafa_pkg::coord_t                     tgt_x,
  input  wire rafa_pkg::coord_t                     tgt_y,
  input  wire rafa_pkg::coord_t                     tgt_w,
  input  wire rafa_pkg::coord_t                     tgt_h,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rafa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [rafa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                      done,
  output rafa_pkg::coord_t                          out_x,
  output rafa_pkg::coord_t                          out_y,
  output rafa_pkg::coord_t                          out_w,
  output rafa_pkg::coord_t                          out_h,
  output logic                                      zero_size_skip,
  output logic                                      saturated
);

  localparam int DLAT       = rafa_pkg::DIV_LAT;
  localparam int PIPE_DEPTH = 2 + rafa_pkg::DIV_LAT + 5;

  function automatic rafa_pkg::anc_t anchor_of(input rafa_pkg::coord_t p,
                                               input rafa_pkg::coord_t s,
                                               input rafa_pkg::anchor_t code);
    rafa_pkg::anc_t pa;
    rafa_pkg::anc_t ea;
    rafa_pkg::anc_t r;
    pa = rafa_pkg::anc_t'(p);
    ea = pa + rafa_pkg::anc_t'(s);
    case (code)
      rafa_pkg::ANCHOR_NEAR: r = (pa < ea) ? pa : ea;
      rafa_pkg::ANCHOR_FAR:  r = (pa > ea) ? pa : ea;
      default:               r = pa + rafa_pkg::anc_t'(s >>> 1);
    endcase
    return r;
  endfunction

  function automatic rafa_pkg::sat_coord_t scale_fix(input logic neg,
      input logic [rafa_pkg::SCALED_BITS-1:0] m);
    rafa_pkg::sat_coord_t r;
    logic [rafa_pkg::SCALED_BITS-1:0] limit;
    limit = rafa_pkg::SCALED_BITS'(1) << (rafa_pkg::COORD_BITS - 1);
    r.sat = 1'b0;
    if (neg) begin
      if (m > limit) begin
        r.sat = 1'b1;
        r.val = rafa_pkg::WORD_MIN;
      end else begin
        r.val = -rafa_pkg::coord_t'(m[rafa_pkg::COORD_BITS-1:0]);
      end
    end else begin
      if (m[rafa_pkg::SCALED_BITS-1:rafa_pkg::COORD_BITS-1] != '0) begin
        r.sat = 1'b1;
        r.val = rafa_pkg::WORD_MAX;
      end else begin
        r.val = rafa_pkg::coord_t'(m[rafa_pkg::COORD_BITS-1:0]);
      end
    end
    return r;
  endfunction

  function automatic rafa_pkg::sat_coord_t clamp_word(input rafa_pkg::sum_t v);
    rafa_pkg::sat_coord_t r;
    r.sat = 1'b0;
    if (v > rafa_pkg::sum_t'(rafa_pkg::WORD_MAX)) begin
      r.sat = 1'b1;
      r.val = rafa_pkg::WORD_MAX;
    end else if (v < rafa_pkg::sum_t'(rafa_pkg::WORD_MIN)) begin
      r.sat = 1'b1;
      r.val = rafa_pkg::WORD_MIN;
    end else begin
      r.val = rafa_pkg::coord_t'(v[rafa_pkg::COORD_BITS-1:0]);
    end
    return r;
  endfunction

  // Configuration registers.
  rafa_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aspect_mode <= rafa_pkg::MODE_FIT;
      cfg.tgt_horz    <= rafa_pkg::ANCHOR_CENTER;
      cfg.tgt_vert    <= rafa_pkg::ANCHOR_CENTER;
      cfg.subj_horz   <= rafa_pkg::ANCHOR_CENTER;
      cfg.subj_vert   <= rafa_pkg::ANCHOR_CENTER;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rafa_pkg::CFG_ASPECT_MODE: cfg.aspect_mode <= rafa_pkg::mode_t'(cfg_data);
        rafa_pkg::CFG_TGT_HORZ:    cfg.tgt_horz    <= rafa_pkg::anchor_t'(cfg_data);
        rafa_pkg::CFG_TGT_VERT:    cfg.tgt_vert    <= rafa_pkg::anchor_t'(cfg_data);
        rafa_pkg::CFG_SUBJ_HORZ:   cfg.subj_horz   <= rafa_pkg::anchor_t'(cfg_data);
        rafa_pkg::CFG_SUBJ_VERT:   cfg.subj_vert   <= rafa_pkg::anchor_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage 1: request capture.
  logic             v1;
  rafa_pkg::rect_t  subj1;
  rafa_pkg::rect_t  tgt1;
  rafa_pkg::cfg_t   cfg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    subj1 <= '{x: subj_x, y: subj_y, w: subj_w, h: subj_h};
    tgt1  <= '{x: tgt_x, y: tgt_y, w: tgt_w, h: tgt_h};
    cfg1  <= cfg;
  end

  // Stage 2: magnitudes and zero size test.
  logic             v2;
  rafa_pkg::side_t  side2;
  rafa_pkg::mag_t   tw_mag2;
  rafa_pkg::mag_t   th_mag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    side2.subj  <= subj1;
    side2.tgt   <= tgt1;
    side2.cfg   <= cfg1;
    side2.w_mag <= rafa_pkg::mag_of(subj1.w);
    side2.h_mag <= rafa_pkg::mag_of(subj1.h);
    side2.zero  <= (subj1.w == '0) || (subj1.h == '0);
    tw_mag2     <= rafa_pkg::mag_of(tgt1.w);
    th_mag2     <= rafa_pkg::mag_of(tgt1.h);
  end

  // Ratio dividers and the matching delay line for the rest of the request.
  rafa_pkg::div_res_t div_w;
  rafa_pkg::div_res_t div_h;

  rafa_div u_div_w (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .num      (tw_mag2),
    .den      (side2.w_mag),
    .res      (div_w)
  );

  rafa_div u_div_h (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .num      (th_mag2),
    .den      (side2.h_mag),
    .res      (div_h)
  );

  logic            side_v    [0:DLAT-1];
  rafa_pkg::side_t side_pipe [0:DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLAT; k++) begin
        side_v[k] <= 1'b0;
      end
    end else begin
      side_v[0] <= v2;
      for (int k = 1; k < DLAT; k++) begin
        side_v[k] <= side_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_pipe[0] <= side2;
    for (int k = 1; k < DLAT; k++) begin
      side_pipe[k] <= side_pipe[k-1];
    end
  end

  // Stage 3: ratio selection.
  rafa_pkg::ratio_t rw_eff;
  rafa_pkg::ratio_t rh_eff;
  rafa_pkg::ratio_t r_min;
  rafa_pkg::ratio_t r_max;

  logic             v3;
  rafa_pkg::side_t  side3;
  rafa_pkg::ratio_t r3;
  logic             rsat3;

  assign rw_eff = div_w.sat ? '1 : div_w.quot;
  assign rh_eff = div_h.sat ? '1 : div_h.quot;
  assign r_min  = (rw_eff < rh_eff) ? rw_eff : rh_eff;
  assign r_max  = (rw_eff > rh_eff) ? rw_eff : rh_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= side_v[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    side3 <= side_pipe[DLAT-1];
    r3    <= (side_pipe[DLAT-1].cfg.aspect_mode == rafa_pkg::MODE_FIT) ? r_min : r_max;
    rsat3 <= div_w.sat || div_h.sat;
  end

  // Stage 4: size products.
  logic                              v4;
  rafa_pkg::side_t                   side4;
  logic                              rsat4;
  logic [rafa_pkg::PROD_BITS-1:0]    prod_w4;
  logic [rafa_pkg::PROD_BITS-1:0]    prod_h4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    side4   <= side3;
    rsat4   <= rsat3;
    prod_w4 <= rafa_pkg::PROD_BITS'(side3.w_mag) * rafa_pkg::PROD_BITS'(r3);
    prod_h4 <= rafa_pkg::PROD_BITS'(side3.h_mag) * rafa_pkg::PROD_BITS'(r3);
  end

  // Stage 5: product saturation and size by mode.
  rafa_pkg::sat_coord_t sw4;
  rafa_pkg::sat_coord_t sh4;
  logic                 aspect4;
  logic                 scale_on4;
  rafa_pkg::side_t      side5_next;

  logic                 v5;
  rafa_pkg::side_t      side5;
  logic                 sat5;
  logic                 skip5;

  assign sw4       = scale_fix(side4.subj.w[rafa_pkg::COORD_BITS-1],
                               prod_w4[rafa_pkg::PROD_BITS-1:rafa_pkg::FRAC_BITS]);
  assign sh4       = scale_fix(side4.subj.h[rafa_pkg::COORD_BITS-1],
                               prod_h4[rafa_pkg::PROD_BITS-1:rafa_pkg::FRAC_BITS]);
  assign aspect4   = (side4.cfg.aspect_mode == rafa_pkg::MODE_FIT) ||
                     (side4.cfg.aspect_mode == rafa_pkg::MODE_FILL);
  assign scale_on4 = aspect4 && !side4.zero;

  always_comb begin
    side5_next = side4;
    if (side4.cfg.aspect_mode == rafa_pkg::MODE_STRETCH) begin
      side5_next.subj.w = side4.tgt.w;
      side5_next.subj.h = side4.tgt.h;
    end else if (scale_on4) begin
      side5_next.subj.w = sw4.val;
      side5_next.subj.h = sh4.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    side5 <= side5_next;
    sat5  <= scale_on4 && (rsat4 || sw4.sat || sh4.sat);
    skip5 <= aspect4 && side4.zero;
  end

  // Stage 6: anchors.
  logic            v6;
  rafa_pkg::side_t side6;
  logic            sat6;
  logic            skip6;
  logic            en_x6;
  logic            en_y6;
  rafa_pkg::anc_t  at_x6;
  rafa_pkg::anc_t  as_x6;
  rafa_pkg::anc_t  at_y6;
  rafa_pkg::anc_t  as_y6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    side6 <= side5;
    sat6  <= sat5;
    skip6 <= skip5;
    en_x6 <= (side5.cfg.tgt_horz != rafa_pkg::ANCHOR_IGNORE) &&
             (side5.cfg.subj_horz != rafa_pkg::ANCHOR_IGNORE);
    en_y6 <= (side5.cfg.tgt_vert != rafa_pkg::ANCHOR_IGNORE) &&
             (side5.cfg.subj_vert != rafa_pkg::ANCHOR_IGNORE);
    at_x6 <= anchor_of(side5.tgt.x, side5.tgt.w, side5.cfg.tgt_horz);
    as_x6 <= anchor_of(side5.subj.x, side5.subj.w, side5.cfg.subj_horz);
    at_y6 <= anchor_of(side5.tgt.y, side5.tgt.h, side5.cfg.tgt_vert);
    as_y6 <= anchor_of(side5.subj.y, side5.subj.h, side5.cfg.subj_vert);
  end

  // Stage 7: offsets, final clamp and result registers.
  rafa_pkg::sum_t       nx6;
  rafa_pkg::sum_t       ny6;
  rafa_pkg::sat_coord_t cx6;
  rafa_pkg::sat_coord_t cy6;

  assign nx6 = en_x6 ? rafa_pkg::sum_t'(side6.subj.x) + rafa_pkg::sum_t'(at_x6) -
                       rafa_pkg::sum_t'(as_x6)
                     : rafa_pkg::sum_t'(side6.subj.x);
  assign ny6 = en_y6 ? rafa_pkg::sum_t'(side6.subj.y) + rafa_pkg::sum_t'(at_y6) -
                       rafa_pkg::sum_t'(as_y6)
                     : rafa_pkg::sum_t'(side6.subj.y);
  assign cx6 = clamp_word(nx6);
  assign cy6 = clamp_word(ny6);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    out_x          <= cx6.val;
    out_y          <= cy6.val;
    out_w          <= side6.subj.w;
    out_h          <= side6.subj.h;
    zero_size_skip <= skip6;
    saturated      <= sat6 || cx6.sat || cy6.sat;
  end

`ifndef ASSERT_OFF
  a_div_align: assert property (@(posedge clk) disable iff (rst)
    (div_w.valid == side_v[DLAT-1]) && (div_h.valid == side_v[DLAT-1]))
    else $error("Divider results are out of step with the request delay line.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(PIPE_DEPTH) done)
    else $error("Result strobe did not follow a request after the pipeline depth.");

  a_skip_keeps_size: assert property (@(posedge clk) disable iff (rst)
    (v5 && skip5) |-> ((side5.subj.w == $past(side4.subj.w)) &&
                       (side5.subj.h == $past(side4.subj.h))))
    else $error("Size changed although scaling was skipped for a zero dimension.");
`endif

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Rectangle aspect fit and align: self-checking testbench
// A queue of requests and register writes drives the block through directed
// corner cases and random rectangles under several register settings and
// sender pacing. Every result is checked field by field against a predictor.
// ----------------------------------------------------------------------------
module testbench;
  import rafa_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = DIV_LAT + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_RECTS    = 103;

  typedef enum logic [1:0] {
    ITEM_RECT,
    ITEM_CFG,
    ITEM_PACE
  } item_kind_t;

  typedef struct packed {
    item_kind_t               kind;
    rect_t                    subj;
    rect_t                    tgt;
    cfg_index_t               reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    logic [6:0]               idle_pct;
  } req_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    logic   skip;
    logic   sat;
  } placement_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  coord_t                    subj_x = '0;
  coord_t                    subj_y = '0;
  coord_t                    subj_w = '0;
  coord_t                    subj_h = '0;
  coord_t                    tgt_x = '0;
  coord_t                    tgt_y = '0;
  coord_t                    tgt_w = '0;
  coord_t                    tgt_h = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      done;
  coord_t                    out_x;
  coord_t                    out_y;
  coord_t                    out_w;
  coord_t                    out_h;
  logic                      zero_size_skip;
  logic                      saturated;

  req_item_t  pending_reqs[$];
  placement_t placement_q[$];
  cfg_t       model_cfg = {MODE_FIT, ANCHOR_CENTER, ANCHOR_CENTER, ANCHOR_CENTER, ANCHOR_CENTER};
  int         idle_pct = 0;
  int         mismatches = 0;
  int         rect_count = 0;
  int         cfg_count = 0;
  int         skip_count = 0;
  int         sat_count = 0;
  int         quiet_cycles = 0;

  mode_t   mode_seq[4] = '{MODE_STRETCH, MODE_FIT, MODE_FILL, MODE_KEEP};
  anchor_t anc_seq[4]  = '{ANCHOR_IGNORE, ANCHOR_NEAR, ANCHOR_FAR, ANCHOR_CENTER};

  rect_aspect_fit_align uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .subj_x         (subj_x),
    .subj_y         (subj_y),
    .subj_w         (subj_w),
    .subj_h         (subj_h),
    .tgt_x          (tgt_x),
    .tgt_y          (tgt_y),
    .tgt_w          (tgt_w),
    .tgt_h          (tgt_h),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_w          (out_w),
    .out_h          (out_h),
    .zero_size_skip (zero_size_skip),
    .saturated      (saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit out_of_word(input longint v);
    return (v > longint'(WORD_MAX)) || (v < longint'(WORD_MIN));
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  function automatic longint size_ratio(input longint t, input longint d);
    return (magnitude(t) << FRAC_BITS) / magnitude(d);
  endfunction

  function automatic longint scale_by(input longint sz, input longint r);
    longint m;
    m = (magnitude(sz) * r) >>> FRAC_BITS;
    return (sz < 0) ? -m : m;
  endfunction

  function automatic longint anchor_pos(input longint p, input longint sz, input anchor_t code);
    longint e;
    e = p + sz;
    case (code)
      ANCHOR_NEAR: return (p < e) ? p : e;
      ANCHOR_FAR:  return (p > e) ? p : e;
      default:     return p + (sz >>> 1);
    endcase
  endfunction

  function automatic placement_t predict_placement(input rect_t s, input rect_t t,
                                                   input cfg_t c);
    placement_t res;
    longint     x, y, w, h, rw, rh, r, sw, sh;
    logic       sat;
    res = '0;
    sat = 1'b0;
    x = longint'(s.x);
    y = longint'(s.y);
    w = longint'(s.w);
    h = longint'(s.h);
    case (c.aspect_mode)
      MODE_STRETCH: begin
        w = longint'(t.w);
        h = longint'(t.h);
      end
      MODE_FIT, MODE_FILL: begin
        if (w == 0 || h == 0) begin
          res.skip = 1'b1;
        end else begin
          rw = size_ratio(longint'(t.w), w);
          rh = size_ratio(longint'(t.h), h);
          sat = out_of_word(rw) || out_of_word(rh);
          rw = clamp_word(rw);
          rh = clamp_word(rh);
          if (c.aspect_mode == MODE_FIT) r = (rw < rh) ? rw : rh;
          else r = (rw > rh) ? rw : rh;
          sw = scale_by(w, r);
          sh = scale_by(h, r);
          sat = sat || out_of_word(sw) || out_of_word(sh);
          w = clamp_word(sw);
          h = clamp_word(sh);
        end
      end
      default: ;
    endcase
    if (c.tgt_horz != ANCHOR_IGNORE && c.subj_horz != ANCHOR_IGNORE)
      x = x + (anchor_pos(longint'(t.x), longint'(t.w), c.tgt_horz) -
               anchor_pos(x, w, c.subj_horz));
    if (c.tgt_vert != ANCHOR_IGNORE && c.subj_vert != ANCHOR_IGNORE)
      y = y + (anchor_pos(longint'(t.y), longint'(t.h), c.tgt_vert) -
               anchor_pos(y, h, c.subj_vert));
    sat = sat || out_of_word(x) || out_of_word(y);
    res.x = coord_t'(clamp_word(x));
    res.y = coord_t'(clamp_word(y));
    res.w = coord_t'(w);
    res.h = coord_t'(h);
    res.sat = sat;
    return res;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(15, 0))
      0:          return WORD_MIN;
      1:          return WORD_MAX;
      2:          return '0;
      3:          return coord_t'($urandom_range(8, 0)) - coord_t'(4);
      4, 5, 6, 7: return coord_t'($urandom);
      default:    return coord_t'($urandom_range(32'h01FF_FFFF, 0)) - coord_t'(32'h0100_0000);
    endcase
  endfunction

  task automatic push_rect(input rect_t s, input rect_t t);
    req_item_t it;
    it = '0;
    it.kind = ITEM_RECT;
    it.subj = s;
    it.tgt = t;
    pending_reqs.push_back(it);
  endtask

  task automatic push_pace(input int pct);
    req_item_t it;
    it = '0;
    it.kind = ITEM_PACE;
    it.idle_pct = pct[6:0];
    pending_reqs.push_back(it);
  endtask

  task automatic set_config(input cfg_t c);
    req_item_t it;
    it = '0;
    it.kind = ITEM_CFG;
    it.reg_idx = CFG_ASPECT_MODE;
    it.reg_val = c.aspect_mode;
    pending_reqs.push_back(it);
    it.reg_idx = CFG_TGT_HORZ;
    it.reg_val = c.tgt_horz;
    pending_reqs.push_back(it);
    it.reg_idx = CFG_TGT_VERT;
    it.reg_val = c.tgt_vert;
    pending_reqs.push_back(it);
    it.reg_idx = CFG_SUBJ_HORZ;
    it.reg_val = c.subj_horz;
    pending_reqs.push_back(it);
    it.reg_idx = CFG_SUBJ_VERT;
    it.reg_val = c.subj_vert;
    pending_reqs.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [COORD_BITS-1:0] want,
                             input logic [COORD_BITS-1:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_LIMIT)
        $display("ERROR: %s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : driver
    req_item_t head;
    logic      nxt_start;
    logic      nxt_cfg_valid;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      model_cfg = {MODE_FIT, ANCHOR_CENTER, ANCHOR_CENTER, ANCHOR_CENTER, ANCHOR_CENTER};
    end else begin
      if (start && !busy) begin
        placement_q.push_back(predict_placement({subj_x, subj_y, subj_w, subj_h},
                                                {tgt_x, tgt_y, tgt_w, tgt_h}, model_cfg));
        rect_count++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_ASPECT_MODE: model_cfg.aspect_mode = mode_t'(cfg_data);
          CFG_TGT_HORZ:    model_cfg.tgt_horz = anchor_t'(cfg_data);
          CFG_TGT_VERT:    model_cfg.tgt_vert = anchor_t'(cfg_data);
          CFG_SUBJ_HORZ:   model_cfg.subj_horz = anchor_t'(cfg_data);
          CFG_SUBJ_VERT:   model_cfg.subj_vert = anchor_t'(cfg_data);
          default: ;
        endcase
        cfg_count++;
      end
      nxt_start = start && busy;
      nxt_cfg_valid = cfg_valid && !cfg_ready;
      if (!nxt_start && !nxt_cfg_valid && pending_reqs.size() != 0) begin
        head = pending_reqs[0];
        case (head.kind)
          ITEM_PACE: begin
            idle_pct = head.idle_pct;
            void'(pending_reqs.pop_front());
          end
          ITEM_CFG: begin
            if (placement_q.size() == 0) begin
              cfg_index <= head.reg_idx;
              cfg_data <= head.reg_val;
              nxt_cfg_valid = 1'b1;
              void'(pending_reqs.pop_front());
            end
          end
          ITEM_RECT: begin
            if ($urandom_range(99, 0) >= idle_pct) begin
              subj_x <= head.subj.x;
              subj_y <= head.subj.y;
              subj_w <= head.subj.w;
              subj_h <= head.subj.h;
              tgt_x <= head.tgt.x;
              tgt_y <= head.tgt.y;
              tgt_w <= head.tgt.w;
              tgt_h <= head.tgt.h;
              nxt_start = 1'b1;
              void'(pending_reqs.pop_front());
            end
          end
          default: ;
        endcase
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  always @(posedge clk) begin : monitor
    placement_t want;
    if (!rst) begin
      if (done) begin
        if (placement_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("ERROR: result with no request outstanding: x=%h y=%h w=%h h=%h",
                     out_x, out_y, out_w, out_h);
          mismatches++;
        end else begin
          want = placement_q.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_w", want.w, out_w);
          check_field("out_h", want.h, out_h);
          check_field("zero_size_skip", COORD_BITS'(want.skip), COORD_BITS'(zero_size_skip));
          check_field("saturated", COORD_BITS'(want.sat), COORD_BITS'(saturated));
          skip_count += want.skip;
          sat_count += want.sat;
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no progress for %0d cycles, %0d results outstanding",
                 quiet_cycles, placement_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rect_t dir_subj[6];
    rect_t dir_tgt[6];
    rect_t s, t;
    cfg_t  c;
    int    i, j;

    dir_subj[0] = {32'sh0001_8000, -32'sh0002_0000, 32'sh0002_0000, 32'sh0001_0000};
    dir_tgt[0]  = {32'sh0010_0000, 32'sh0008_0000, 32'sh0008_0000, 32'sh0006_0000};
    dir_subj[1] = {32'sh0000_4000, 32'sh0003_0000, 32'sh0000_0000, 32'sh0002_0000};
    dir_tgt[1]  = {-32'sh0001_0000, 32'sh0000_0000, 32'sh0004_0000, 32'sh0004_0000};
    dir_subj[2] = {-32'sh0005_0000, 32'sh0001_0000, -32'sh0003_0001, 32'sh0000_0000};
    dir_tgt[2]  = {32'sh0002_0000, -32'sh0007_0000, 32'sh0009_0003, -32'sh0001_0000};
    dir_subj[3] = {-32'sh0005_0000, 32'sh0003_0000, -32'sh0003_0000, -32'sh0001_8000};
    dir_tgt[3]  = {32'sh0001_0000, -32'sh0002_0000, -32'sh0007_0000, 32'sh0004_0001};
    dir_subj[4] = {WORD_MAX, WORD_MIN, 32'sh0000_0001, -32'sh0000_0001};
    dir_tgt[4]  = {WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX};
    dir_subj[5] = {WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX};
    dir_tgt[5]  = {WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN};

    push_pace(0);
    for (i = 0; i < 4; i++) begin
      c.aspect_mode = mode_seq[i];
      c.tgt_horz = anc_seq[i];
      c.tgt_vert = anc_seq[3 - i];
      c.subj_horz = anc_seq[(i + 1) % 4];
      c.subj_vert = anc_seq[(i + 2) % 4];
      set_config(c);
      for (j = 0; j < 6; j++) push_rect(dir_subj[j], dir_tgt[j]);
    end

    for (i = 0; i < PHASES; i++) begin
      c.tgt_horz = anchor_t'($urandom_range(3, 0));
      c.tgt_vert = anchor_t'($urandom_range(3, 0));
      c.subj_horz = anchor_t'($urandom_range(3, 0));
      c.subj_vert = anchor_t'($urandom_range(3, 0));
      case (i)
        0: c = {MODE_STRETCH, ANCHOR_IGNORE, ANCHOR_IGNORE, ANCHOR_IGNORE, ANCHOR_IGNORE};
        1: c = {MODE_KEEP, ANCHOR_CENTER, ANCHOR_CENTER, ANCHOR_CENTER, ANCHOR_CENTER};
        2, 4: c.aspect_mode = MODE_FIT;
        3, 5: c.aspect_mode = MODE_FILL;
        default: c.aspect_mode = mode_t'($urandom_range(3, 0));
      endcase
      set_config(c);
      case (i % 4)
        0: push_pace(0);
        1: push_pace(72);
        2: push_pace(36);
        default: push_pace(72);
      endcase
      for (j = 0; j < PHASE_RECTS; j++) begin
        s = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        t = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        push_rect(s, t);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || start || cfg_valid || placement_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += placement_q.size();

    $display("Checked %0d rectangles over %0d register writes in %0d register settings.",
             rect_count, cfg_count, PHASES + 4);
    $display("Zero-size skips seen: %0d; saturated results seen: %0d.", skip_count, sat_count);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rafa_pkg.sv
rtl/rafa_div.sv
rtl/rect_aspect_fit_align.sv
dv/testbench.sv
